// ----- rtl/ctg_pkg.sv -----
// Shared types, widths and the quarter-wave cosine table of the tone generator.
// No dependencies; imported by every module of the block.

package ctg_pkg;

   // Datapath widths
   localparam int PHASE_BITS       = 32;
   localparam int TABLE_INDEX_BITS = 12;
   localparam int COUNT_BITS       = 24;
   localparam int SAMPLE_BITS      = 16;
   localparam int MAG_BITS         = SAMPLE_BITS - 1;

   // Register file widths and reset values
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 32;
   localparam int STEP_REG_BITS   = 32;
   localparam int COUNT_REG_BITS  = 24;
   localparam logic [STEP_REG_BITS-1:0]  STEP_RESET  = 32'd42852281;
   localparam logic [COUNT_REG_BITS-1:0] COUNT_RESET = 24'd22050;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_COUNT = 1'b1;

   // Quarter table: QTR_SIZE + 1 entries, both end points stored
   localparam int QTR_BITS      = TABLE_INDEX_BITS - 2;
   localparam int QTR_SIZE      = 1 << QTR_BITS;
   localparam int ROM_ADDR_BITS = QTR_BITS + 1;
   localparam int AMPLITUDE     = 32767;

   // Q62 constants for building the table
   localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
   localparam int          TAYLOR_TERMS = 12;
   localparam int          DIV_BITS     = 10;

   typedef logic [MAG_BITS-1:0] qtr_rom_type [0:QTR_SIZE];

   // One table lookup request handed from the phase stage to the lookup stage
   typedef struct packed {
      logic [ROM_ADDR_BITS-1:0] rom_addr;
      logic                     negate;
      logic                     last;
   } ctg_lookup_req_type;

   // Truncated Q62 product
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Truncating divide by a small factor, restoring shift and subtract
   function automatic logic [63:0] div_small(input logic [63:0] num,
                                             input logic [DIV_BITS-1:0] den);
      logic [63:0]       quo;
      logic [DIV_BITS:0] rem;
      int                i;
      quo = '0;
      rem = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[DIV_BITS-1:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Cosine of a Q62 angle in [0, pi/2], Horner form of the Taylor series
   function automatic logic [63:0] cos_q62(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      int          k;
      x2 = mul_q62(x, x);
      t  = Q62_ONE;
      for (k = TAYLOR_TERMS; k >= 1; k--) begin
         p = div_small(mul_q62(x2, t), DIV_BITS'((2 * k) * (2 * k - 1)));
         t = (p >= Q62_ONE) ? 64'd0 : Q62_ONE - p;
      end
      return t;
   endfunction

   // Build the quarter-wave magnitude table at elaboration
   function automatic qtr_rom_type build_rom();
      qtr_rom_type rom;
      logic [63:0] u;
      logic [63:0] v;
      int          r;
      for (r = 0; r <= QTR_SIZE; r++) begin
         u = 64'(r) << (64 - TABLE_INDEX_BITS);
         v = mul_q62(cos_q62(mul_q62(HALF_PI_Q62, u)), 64'(AMPLITUDE));
         if (r == 0)        v = 64'(AMPLITUDE);
         if (r == QTR_SIZE) v = 64'd0;
         if (v > 64'(AMPLITUDE)) v = 64'(AMPLITUDE);
         rom[r] = MAG_BITS'(v);
      end
      return rom;
   endfunction

   localparam qtr_rom_type QTR_ROM = build_rom();

endpackage

// ----- rtl/cosine_tone_generator_top.sv -----
// Top level of the cosine tone generator: register file and the two pipe stages.
// Depends on ctg_pkg, ctg_phase and ctg_lookup.
//
// Usage: every word on the req_ stream is one sample tick; bit 0 of req_tdata is
// restart, which forces phase and sample index to zero for that tick. Each tick
// gives exactly one word on the rsp_ stream: a signed 16-bit cosine sample in
// rsp_tdata and rsp_tlast high on the final sample of a run of sample_count.
// The next sample after rsp_tlast starts at phase zero again.
// The word passes through three register stages from req_ acceptance to rsp_tvalid:
// phase stage (loaded at acceptance), registered table read, sign and output
// register. Throughput is one sample per cycle while the receiver does not stall,
// set by the phase add and the one-port table read.
// Each stage has its own valid bit, so empty stages keep filling while the
// receiver stalls; req_tready falls only when all three stages hold a word.
// The csr_ port writes phase_step (index 0) or sample_count (index 1); it is
// always ready and should be written only while the block is idle.
// Synchronous reset clears phase, index and all valid bits and restores the
// default 440 Hz at 44.1 kHz step and a run of 22050 samples.

module cosine_tone_generator_top
   import ctg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Tick stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [0] restart, [7:1] zero
   // Sample stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [SAMPLE_BITS-1:0]    rsp_tdata,   // [15:0] sample
   output logic                      rsp_tlast,
   // Register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [STEP_REG_BITS-1:0]  step_ff, step_in;
   logic [COUNT_REG_BITS-1:0] count_ff, count_in;
   logic                      look_valid;
   logic                      look_ready;
   ctg_lookup_req_type        look_req;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      step_in  = step_ff;
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_STEP:   step_in  = csr_data[STEP_REG_BITS-1:0];
            CSR_SAMPLE_COUNT: count_in = csr_data[COUNT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_RESET;
         count_ff <= COUNT_RESET;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   ctg_phase u_phase (
      .clock        (clock),
      .reset        (reset),
      .phase_step   (PHASE_BITS'(step_ff)),
      .sample_count (COUNT_BITS'(count_ff)),
      .tick_valid   (req_tvalid),
      .tick_ready   (req_tready),
      .restart      (req_tdata[0]),
      .look_valid   (look_valid),
      .look_ready   (look_ready),
      .look_req     (look_req)
   );

   ctg_lookup u_lookup (
      .clock      (clock),
      .reset      (reset),
      .look_valid (look_valid),
      .look_ready (look_ready),
      .look_req   (look_req),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

// ----- rtl/ctg_phase.sv -----
// Phase accumulator and sample counter of the tone generator; first pipe stage.
// Depends on ctg_pkg; feeds ctg_lookup with one table request per tick.

module ctg_phase
   import ctg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [PHASE_BITS-1:0]    phase_step,
   input  logic [COUNT_BITS-1:0]    sample_count,
   input  logic                     tick_valid,
   output logic                     tick_ready,
   input  logic                     restart,
   output logic                     look_valid,
   input  logic                     look_ready,
   output ctg_lookup_req_type       look_req
);

   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [COUNT_BITS-1:0]       index_ff, index_in;
   logic                        valid_ff, valid_in;
   ctg_lookup_req_type          req_ff, req_in;
   logic [PHASE_BITS-1:0]       cur_phase;
   logic [COUNT_BITS-1:0]       cur_index;
   logic [COUNT_BITS-1:0]       count_m1;
   logic [TABLE_INDEX_BITS-1:0] table_idx;
   logic [1:0]                  quadrant;
   logic [QTR_BITS-1:0]         qtr_pos;
   logic                        is_last;
   logic                        accept;

   // Take a tick whenever the stage is empty or drains this cycle
   assign tick_ready = !valid_ff || look_ready;
   assign accept     = tick_valid && tick_ready;

   // Current phase and index, cleared on restart
   assign cur_phase = restart ? '0 : phase_ff;
   assign cur_index = restart ? '0 : index_ff;
   assign count_m1  = COUNT_BITS'(sample_count - 1'b1);
   assign is_last   = (cur_index == count_m1);

   // Split the table index into quadrant and position within the quarter
   assign table_idx = cur_phase[PHASE_BITS-1 -: TABLE_INDEX_BITS];
   assign quadrant  = table_idx[TABLE_INDEX_BITS-1 -: 2];
   assign qtr_pos   = table_idx[QTR_BITS-1:0];

   // Mirror the address in odd quadrants, negate in the middle two
   always_comb begin
      req_in.rom_addr = quadrant[0]
         ? ROM_ADDR_BITS'(QTR_SIZE - int'(qtr_pos))
         : {1'b0, qtr_pos};
      req_in.negate   = quadrant[1] ^ quadrant[0];
      req_in.last     = is_last;
   end

   // Advance state, return to zero after the last word of a run
   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      if (accept) begin
         if (is_last) begin
            phase_in = '0;
            index_in = '0;
         end else begin
            phase_in = cur_phase + phase_step;
            index_in = cur_index + 1'b1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (tick_ready) begin
         valid_in = tick_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

   assign look_valid = valid_ff;
   assign look_req   = req_ff;

   // A run end puts phase and index back to zero
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && is_last) |=> (phase_ff == '0 && index_ff == '0))
      else $error("phase or index not cleared after last word");

   // Table address stays within the stored quarter
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (int'(req_ff.rom_addr) <= QTR_SIZE))
      else $error("table address out of range");

endmodule

// ----- rtl/ctg_lookup.sv -----
// Cosine table read and sign stage of the tone generator; holds the result register.
// Depends on ctg_pkg for the quarter-wave table and the request type.

module ctg_lookup
   import ctg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     look_valid,
   output logic                     look_ready,
   input  ctg_lookup_req_type       look_req,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [SAMPLE_BITS-1:0]   out_sample,
   output logic                     out_last
);

   logic                   rd_valid_ff, rd_valid_in;
   logic [MAG_BITS-1:0]    rd_mag_ff;
   logic                   rd_negate_ff;
   logic                   rd_last_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                   out_last_ff;
   logic                   out_free;
   logic                   rd_load;
   logic                   out_load;

   // Per-stage flow control so bubbles fill while the output waits
   assign out_free   = !out_valid_ff || out_ready;
   assign look_ready = !rd_valid_ff || out_free;
   assign rd_load    = look_valid && look_ready;
   assign out_load   = rd_valid_ff && out_free;

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (look_ready) begin
         rd_valid_in = look_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Registered table read
   always_ff @(posedge clock) begin
      if (rd_load) begin
         rd_mag_ff    <= QTR_ROM[look_req.rom_addr];
         rd_negate_ff <= look_req.negate;
         rd_last_ff   <= look_req.last;
      end
   end

   // Apply the quadrant sign
   assign out_sample_in = rd_negate_ff
      ? SAMPLE_BITS'(0 - {1'b0, rd_mag_ff})
      : {1'b0, rd_mag_ff};

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_sample_ff <= out_sample_in;
         out_last_ff   <= rd_last_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_sample_ff;
   assign out_last   = out_last_ff;

   // Magnitude never exceeds the amplitude, so the most negative code never shows
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_sample_ff != {1'b1, {MAG_BITS{1'b0}}}))
      else $error("sample took the most negative code");

   // A read word blocked by a full output stays in the read stage
   a_rd_holds: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && !out_free) |=> rd_valid_ff)
      else $error("read stage word lost under stall");

   // Output register only fills from a valid read stage
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && !rd_valid_ff) |=> !out_valid_ff)
      else $error("output word appeared without a source");

endmodule
